// ----- src/pra_pkg.sv -----
// ----------------------------------------------------------------------------
// pra_pkg: shared types and constants of the physical register allocator
// Action and fault codes, the controller states and the control bundle that
// the allocation logic hands to the top level.
// ----------------------------------------------------------------------------
package pra_pkg;

    // Default sizes of the register files.
    localparam int PRA_NUM_PHYS = 8;
    localparam int PRA_NUM_VIRT = 256;

    // Fixed field widths of the instruction channel.
    localparam int PRA_VREG_W   = 8;
    localparam int PRA_ACTION_W = 2;

    // Requested operation; the fourth code is unused and does nothing.
    typedef enum logic [PRA_ACTION_W-1:0] {
        ACT_ALLOC_DEST = 2'd0,
        ACT_ALLOC_BOTH = 2'd1,
        ACT_RELEASE    = 2'd2
    } action_t;

    // Fault reported with a result.
    typedef enum logic [1:0] {
        FAULT_OK          = 2'd0,
        FAULT_EXHAUSTED   = 2'd1,
        FAULT_FREE_MAP    = 2'd2,
        FAULT_BAD_RELEASE = 2'd3
    } fault_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEST,
        ST_EXEC,
        ST_WSRC
    } state_t;

    // Decision of the allocation logic for one instruction.
    typedef struct packed {
        fault_t fault;
        logic   src_valid;
        logic   dest_new;
        logic   src_new;
    } alloc_ctl_t;

endpackage

// ----- src/pra_if.sv -----
// ----------------------------------------------------------------------------
// pra_if: valid/ready channels of the physical register allocator
// pra_req_if carries one instruction per transfer, pra_rsp_if one result.
// ----------------------------------------------------------------------------
interface pra_req_if;
    logic                          valid;
    logic                          ready;
    logic [pra_pkg::PRA_ACTION_W-1:0] action;
    logic [pra_pkg::PRA_VREG_W-1:0]   dest_vreg;
    logic [pra_pkg::PRA_VREG_W-1:0]   src_vreg;
    logic                          src_is_imm;

    modport source (output valid, action, dest_vreg, src_vreg, src_is_imm, input ready);
    modport sink   (input valid, action, dest_vreg, src_vreg, src_is_imm, output ready);
endinterface

interface pra_rsp_if #(
    parameter int PHYS_W = $clog2(pra_pkg::PRA_NUM_PHYS)
);
    logic              valid;
    logic              ready;
    logic [PHYS_W-1:0] dest_phys;
    logic [PHYS_W-1:0] src_phys;
    logic              src_phys_valid;
    pra_pkg::fault_t   fault;

    modport source (output valid, dest_phys, src_phys, src_phys_valid, fault, input ready);
    modport sink   (input valid, dest_phys, src_phys, src_phys_valid, fault, output ready);
endinterface

// ----- src/pra_ram.sv -----
// ----------------------------------------------------------------------------
// pra_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module pra_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- src/pra_alloc.sv -----
// ----------------------------------------------------------------------------
// pra_alloc: allocation decision for one instruction
// Given the busy mask and the two map entries read from the rename map,
// picks or checks the physical registers and reports the fault, if any.
// ----------------------------------------------------------------------------
module pra_alloc #(
    parameter int NUM_PHYS = pra_pkg::PRA_NUM_PHYS,
    parameter int PHYS_W   = $clog2(pra_pkg::PRA_NUM_PHYS),
    parameter int VIRT_W   = $clog2(pra_pkg::PRA_NUM_VIRT)
) (
    input  pra_pkg::action_t    action,
    input  logic                src_is_imm,
    input  logic [VIRT_W-1:0]   dest_idx,
    input  logic [VIRT_W-1:0]   src_idx,
    input  logic [NUM_PHYS-1:0] busy,
    input  logic                dest_hit,
    input  logic [PHYS_W-1:0]   dest_map,
    input  logic                src_hit,
    input  logic [PHYS_W-1:0]   src_map,
    output pra_pkg::alloc_ctl_t ctl,
    output logic [PHYS_W-1:0]   dest_phys,
    output logic [PHYS_W-1:0]   src_phys,
    output logic [NUM_PHYS-1:0] busy_next
);

    import pra_pkg::*;

    // Lowest free register: {found, index}.
    function automatic logic [PHYS_W:0] pick_free(input logic [NUM_PHYS-1:0] mask);
        logic [PHYS_W:0] res;
        res = '0;
        for (int i = NUM_PHYS - 1; i >= 0; i--)
        begin
            if (!mask[i])
            begin
                res = {1'b1, PHYS_W'(i)};
            end
        end
        return res;
    endfunction

    // A mapped register must name an existing register that is still busy.
    function automatic logic mapped_ok(input logic [PHYS_W-1:0] p,
                                       input logic [NUM_PHYS-1:0] mask);
        return (int'(p) < NUM_PHYS) && mask[p];
    endfunction

    logic [PHYS_W:0]     pick_d;
    logic [PHYS_W:0]     pick_s;
    logic [NUM_PHYS-1:0] busy_d;

    // Lowest free register for the destination, then for the source with the
    // destination's new register already taken.
    always_comb
    begin
        pick_d = pick_free(busy);
        busy_d = busy;
        if (!dest_hit && pick_d[PHYS_W])
        begin
            busy_d = busy | (NUM_PHYS'(1) << pick_d[PHYS_W-1:0]);
        end
        pick_s = pick_free(busy_d);
    end

    // Decision for the instruction.
    always_comb
    begin
        ctl       = '{fault: FAULT_OK, src_valid: 1'b0, dest_new: 1'b0, src_new: 1'b0};
        dest_phys = '0;
        src_phys  = '0;
        busy_next = busy;
        case (action)
            ACT_ALLOC_DEST, ACT_ALLOC_BOTH:
            begin
                // Destination: existing mapping or lowest free register.
                if (dest_hit)
                begin
                    if (mapped_ok(dest_map, busy))
                    begin
                        dest_phys = dest_map;
                    end
                    else
                    begin
                        ctl.fault = FAULT_FREE_MAP;
                    end
                end
                else if (pick_d[PHYS_W])
                begin
                    dest_phys    = pick_d[PHYS_W-1:0];
                    ctl.dest_new = 1'b1;
                end
                else
                begin
                    ctl.fault = FAULT_EXHAUSTED;
                end

                // Source, unless it is an immediate.
                if (ctl.fault == FAULT_OK && action == ACT_ALLOC_BOTH && !src_is_imm)
                begin
                    if (ctl.dest_new && src_idx == dest_idx)
                    begin
                        src_phys = dest_phys;
                    end
                    else if (src_hit)
                    begin
                        if (mapped_ok(src_map, busy_d))
                        begin
                            src_phys = src_map;
                        end
                        else
                        begin
                            ctl.fault = FAULT_FREE_MAP;
                        end
                    end
                    else if (pick_s[PHYS_W])
                    begin
                        src_phys    = pick_s[PHYS_W-1:0];
                        ctl.src_new = 1'b1;
                    end
                    else
                    begin
                        ctl.fault = FAULT_EXHAUSTED;
                    end
                    ctl.src_valid = (ctl.fault == FAULT_OK);
                end

                if (ctl.fault == FAULT_OK)
                begin
                    busy_next = busy_d;
                    if (ctl.src_new)
                    begin
                        busy_next = busy_d | (NUM_PHYS'(1) << src_phys);
                    end
                end
                else
                begin
                    // A fault drops everything, including the destination.
                    ctl.src_valid = 1'b0;
                    ctl.dest_new  = 1'b0;
                    ctl.src_new   = 1'b0;
                    dest_phys     = '0;
                    src_phys      = '0;
                end
            end
            ACT_RELEASE:
            begin
                // Free the destination's register; the map entry stays.
                if (dest_hit && mapped_ok(dest_map, busy))
                begin
                    dest_phys = dest_map;
                    busy_next = busy & ~(NUM_PHYS'(1) << dest_map);
                end
                else
                begin
                    ctl.fault = FAULT_BAD_RELEASE;
                end
            end
            default:
            begin
                // Unused action code: no effect, all fields zero.
            end
        endcase
    end

endmodule

// ----- src/physical_register_allocator.sv -----
// ----------------------------------------------------------------------------
// physical_register_allocator: rename map and first-free register allocator
// Flow: an instruction passes ST_DEST and ST_EXEC, then its result waits in
// the output register; ST_EXEC holds while that register is still full. One
// instruction at a time: the next is taken after ST_EXEC, or after ST_WSRC
// when a source is newly mapped. Reset: busy mask cleared, map swept, then ready.
// ----------------------------------------------------------------------------
module physical_register_allocator #(
    parameter int NUM_PHYS = pra_pkg::PRA_NUM_PHYS,
    parameter int NUM_VIRT = pra_pkg::PRA_NUM_VIRT
) (
    input  logic      clk,
    input  logic      rst_n,
    pra_req_if.sink   instr,
    pra_rsp_if.source alloc
);

    import pra_pkg::*;

    localparam int PHYS_W = $clog2(NUM_PHYS);
    localparam int VIRT_W = $clog2(NUM_VIRT);
    localparam int ENT_W  = PHYS_W + 1;

    // Virtual register number reduced modulo NUM_VIRT (quotient below 16).
    function automatic logic [VIRT_W-1:0] vreg_index(input logic [PRA_VREG_W-1:0] v);
        int r;
        r = int'(v);
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= (NUM_VIRT << k))
            begin
                r = r - (NUM_VIRT << k);
            end
        end
        return VIRT_W'(r);
    endfunction

    state_t              state_reg;
    state_t              state_next;
    logic [VIRT_W-1:0]   clr_cnt_reg;
    logic [VIRT_W-1:0]   dest_idx_reg;
    logic [VIRT_W-1:0]   src_idx_reg;
    action_t             action_reg;
    logic                imm_reg;
    logic                dent_valid_reg;
    logic [PHYS_W-1:0]   dent_phys_reg;
    logic [PHYS_W-1:0]   src_wr_reg;
    logic [NUM_PHYS-1:0] busy_reg;
    logic                out_valid_reg;
    logic [PHYS_W-1:0]   out_dest_reg;
    logic [PHYS_W-1:0]   out_src_reg;
    logic                out_srcv_reg;
    fault_t              out_fault_reg;

    logic                ram_we;
    logic [VIRT_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]    ram_wdata;
    logic [VIRT_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]    ram_rdata;

    alloc_ctl_t          a_ctl;
    logic [PHYS_W-1:0]   a_dest_phys;
    logic [PHYS_W-1:0]   a_src_phys;
    logic [NUM_PHYS-1:0] a_busy_next;
    logic                exec_go;

    // Rename map: one valid bit and a physical register number per entry.
    pra_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_VIRT)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Allocation decision from the two entries read.
    pra_alloc #(
        .NUM_PHYS (NUM_PHYS),
        .PHYS_W   (PHYS_W),
        .VIRT_W   (VIRT_W)
    ) u_alloc (
        .action     (action_reg),
        .src_is_imm (imm_reg),
        .dest_idx   (dest_idx_reg),
        .src_idx    (src_idx_reg),
        .busy       (busy_reg),
        .dest_hit   (dent_valid_reg),
        .dest_map   (dent_phys_reg),
        .src_hit    (ram_rdata[PHYS_W]),
        .src_map    (ram_rdata[PHYS_W-1:0]),
        .ctl        (a_ctl),
        .dest_phys  (a_dest_phys),
        .src_phys   (a_src_phys),
        .busy_next  (a_busy_next)
    );

    // The result commits once the output register can take it.
    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || alloc.ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == VIRT_W'(NUM_VIRT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (instr.valid)
                begin
                    state_next = ST_DEST;
                end
            end
            ST_DEST:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = a_ctl.src_new ? ST_WSRC : ST_IDLE;
                end
            end
            ST_WSRC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs: handshake and map RAM controls.
    always_comb
    begin
        instr.ready = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = dest_idx_reg;
        ram_wdata   = {1'b1, a_dest_phys};
        ram_raddr   = src_idx_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                instr.ready = 1'b1;
                ram_raddr   = vreg_index(instr.dest_vreg);
            end
            ST_EXEC:
            begin
                ram_we = exec_go && a_ctl.dest_new;
            end
            ST_WSRC:
            begin
                ram_we    = 1'b1;
                ram_waddr = src_idx_reg;
                ram_wdata = {1'b1, src_wr_reg};
            end
            default:
            begin
            end
        endcase
    end

    // Controller state, sweep counter and busy mask.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            busy_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + VIRT_W'(1);
            end
            if (exec_go)
            begin
                busy_reg <= a_busy_next;
            end
        end
    end

    // Instruction fields, the destination entry held for the decision and the new source register for ST_WSRC.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && instr.valid)
        begin
            action_reg   <= action_t'(instr.action);
            imm_reg      <= instr.src_is_imm;
            dest_idx_reg <= vreg_index(instr.dest_vreg);
            src_idx_reg  <= vreg_index(instr.src_vreg);
        end
        if (state_reg == ST_DEST)
        begin
            dent_valid_reg <= ram_rdata[PHYS_W];
            dent_phys_reg  <= ram_rdata[PHYS_W-1:0];
        end
        if (exec_go)
        begin
            src_wr_reg <= a_src_phys;
        end
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (alloc.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            out_dest_reg  <= a_dest_phys;
            out_src_reg   <= a_src_phys;
            out_srcv_reg  <= a_ctl.src_valid;
            out_fault_reg <= a_ctl.fault;
        end
    end

    assign alloc.valid          = out_valid_reg;
    assign alloc.dest_phys      = out_dest_reg;
    assign alloc.src_phys       = out_src_reg;
    assign alloc.src_phys_valid = out_srcv_reg;
    assign alloc.fault          = out_fault_reg;

endmodule

// ----- src/pra_checker.sv -----
// ----------------------------------------------------------------------------
// pra_checker: port-level checks of the physical register allocator
// Watches the two channels and is bound to the top level below.
// ----------------------------------------------------------------------------
module pra_checker #(
    parameter int NUM_PHYS = pra_pkg::PRA_NUM_PHYS
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [$clog2(NUM_PHYS)-1:0] dest_phys,
    input logic [$clog2(NUM_PHYS)-1:0] src_phys,
    input logic                        src_phys_valid,
    input pra_pkg::fault_t             fault
);

    import pra_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // One instruction at a time: no transfer right after a transfer.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("instruction taken while another is in progress");

    // A faulting result carries no register numbers.
    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault != FAULT_OK |->
            dest_phys == '0 && src_phys == '0 && !src_phys_valid)
        else $error("faulting result carries register numbers");

    // A valid source mapping only comes with a clean result.
    a_src_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && src_phys_valid |-> fault == FAULT_OK)
        else $error("source mapped on a faulting result");

endmodule

bind physical_register_allocator pra_checker #(
    .NUM_PHYS (NUM_PHYS)
) u_pra_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (instr.valid),
    .in_ready       (instr.ready),
    .out_valid      (alloc.valid),
    .out_ready      (alloc.ready),
    .dest_phys      (alloc.dest_phys),
    .src_phys       (alloc.src_phys),
    .src_phys_valid (alloc.src_phys_valid),
    .fault          (alloc.fault)
);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for physical_register_allocator
// Instructions are sent over the request channel with random gaps. Each
// transfer is run through a predictor that keeps its own rename map and busy
// mask. Every result transfer is compared field by field with the oldest
// predicted grant. A directed opening covers lookups, first-free picks,
// exhaustion, stale mappings, bad releases, dropped allocations and the
// unused action code. Random traffic over small sliding vreg windows follows.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pra_pkg::*;

    localparam int PHYS_W         = $clog2(PRA_NUM_PHYS);
    localparam int RANDOM_ITEMS   = 1250;
    localparam int CALM_TAIL      = 150;
    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;

    // Action code that the block ignores.
    localparam logic [PRA_ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [PRA_ACTION_W-1:0] action;
        logic [PRA_VREG_W-1:0]   dest_vreg;
        logic [PRA_VREG_W-1:0]   src_vreg;
        logic                    src_is_imm;
    } instr_t;

    typedef struct {
        logic [PHYS_W-1:0] dest_phys;
        logic [PHYS_W-1:0] src_phys;
        logic              src_valid;
        fault_t            fault;
    } grant_t;

    logic clk;
    logic rst_n;

    pra_req_if instr_ch ();
    pra_rsp_if alloc_ch ();

    physical_register_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .instr (instr_ch),
        .alloc (alloc_ch)
    );

    // Predictor state: rename map and busy mask.
    logic              vmap_valid [PRA_NUM_VIRT];
    logic [PHYS_W-1:0] vmap_phys  [PRA_NUM_VIRT];
    logic [PRA_NUM_PHYS-1:0] busy_regs;

    instr_t pending_q [$];
    grant_t grant_q   [$];

    int   mismatches;
    int   send_gap;
    int   sink_gap;
    int   long_hold_left;
    int   stalled_cycles;
    logic long_hold_start;
    logic long_hold_done;
    logic req_taken;

    // Looks up a virtual register or takes the lowest free physical register
    // in the working mask. A mapping made earlier in the same instruction wins.
    function automatic fault_t resolve_vreg(
        input  logic [PRA_VREG_W-1:0]   vreg,
        inout  logic [PRA_NUM_PHYS-1:0] work,
        input  logic                    pend,
        input  logic [PRA_VREG_W-1:0]   pend_vreg,
        input  logic [PHYS_W-1:0]       pend_phys,
        output logic [PHYS_W-1:0]       phys,
        output logic                    is_new
    );
        logic found;
        found  = 1'b0;
        phys   = '0;
        is_new = 1'b0;
        if (pend && vreg == pend_vreg) begin
            phys = pend_phys;
            return FAULT_OK;
        end
        if (vmap_valid[vreg]) begin
            if (!work[vmap_phys[vreg]])
                return FAULT_FREE_MAP;
            phys = vmap_phys[vreg];
            return FAULT_OK;
        end
        for (int i = 0; i < PRA_NUM_PHYS; i++) begin
            if (!found && !work[i]) begin
                work[i] = 1'b1;
                phys    = PHYS_W'(i);
                is_new  = 1'b1;
                found   = 1'b1;
            end
        end
        return found ? FAULT_OK : FAULT_EXHAUSTED;
    endfunction

    // Works out the grant of one instruction and commits it to the map.
    function automatic grant_t predict_grant(instr_t ins);
        grant_t                  g;
        logic [PRA_NUM_PHYS-1:0] work;
        logic [PHYS_W-1:0]       dp;
        logic [PHYS_W-1:0]       sp;
        logic [PHYS_W-1:0]       p;
        logic                    dnew;
        logic                    snew;
        fault_t                  f;
        g.dest_phys = '0;
        g.src_phys  = '0;
        g.src_valid = 1'b0;
        g.fault     = FAULT_OK;
        snew        = 1'b0;
        if (ins.action == ACT_RELEASE) begin
            p = vmap_phys[ins.dest_vreg];
            if (!vmap_valid[ins.dest_vreg] || !busy_regs[p]) begin
                g.fault = FAULT_BAD_RELEASE;
            end
            else begin
                busy_regs[p] = 1'b0;
                g.dest_phys  = p;
            end
        end
        else if (ins.action == ACT_ALLOC_DEST || ins.action == ACT_ALLOC_BOTH) begin
            work = busy_regs;
            f = resolve_vreg(ins.dest_vreg, work, 1'b0, '0, '0, dp, dnew);
            if (f == FAULT_OK && ins.action == ACT_ALLOC_BOTH && !ins.src_is_imm) begin
                f = resolve_vreg(ins.src_vreg, work, dnew, ins.dest_vreg, dp, sp, snew);
                g.src_valid = (f == FAULT_OK);
            end
            if (f == FAULT_OK) begin
                busy_regs = work;
                if (dnew) begin
                    vmap_valid[ins.dest_vreg] = 1'b1;
                    vmap_phys[ins.dest_vreg]  = dp;
                end
                if (snew) begin
                    vmap_valid[ins.src_vreg] = 1'b1;
                    vmap_phys[ins.src_vreg]  = sp;
                end
                g.dest_phys = dp;
                g.src_phys  = g.src_valid ? sp : '0;
            end
            else begin
                g.fault     = f;
                g.src_valid = 1'b0;
            end
        end
        return g;
    endfunction

    task automatic add_instr(
        input logic [PRA_ACTION_W-1:0] action,
        input logic [PRA_VREG_W-1:0]   dest_vreg,
        input logic [PRA_VREG_W-1:0]   src_vreg,
        input logic                    src_is_imm
    );
        instr_t ins;
        ins.action     = action;
        ins.dest_vreg  = dest_vreg;
        ins.src_vreg   = src_vreg;
        ins.src_is_imm = src_is_imm;
        pending_q.push_back(ins);
    endtask

    // Mostly a vreg from the current window, now and then any vreg at all.
    function automatic logic [PRA_VREG_W-1:0] pick_vreg(int base);
        if ($urandom_range(0, 9) == 0)
            return PRA_VREG_W'($urandom_range(0, PRA_NUM_VIRT - 1));
        return PRA_VREG_W'(base + $urandom_range(0, 15));
    endfunction

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Clock.
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Request driver: holds an item until its transfer, then moves on.
    always @(negedge clk) begin : drive_instr
        instr_t nxt;
        if (!rst_n) begin
            instr_ch.valid <= 1'b0;
        end
        else if (!instr_ch.valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                instr_ch.valid <= 1'b0;
            end
            else if (pending_q.size() > CALM_TAIL && $urandom_range(0, 99) < 15) begin
                send_gap = $urandom_range(0, 4);
                instr_ch.valid <= 1'b0;
            end
            else if (pending_q.size() > 0) begin
                nxt = pending_q.pop_front();
                instr_ch.valid      <= 1'b1;
                instr_ch.action     <= nxt.action;
                instr_ch.dest_vreg  <= nxt.dest_vreg;
                instr_ch.src_vreg   <= nxt.src_vreg;
                instr_ch.src_is_imm <= nxt.src_is_imm;
            end
            else begin
                instr_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus one long hold to back the block up.
    always @(negedge clk) begin
        if (!rst_n) begin
            alloc_ch.ready <= 1'b0;
        end
        else if (long_hold_left > 0) begin
            long_hold_left--;
            alloc_ch.ready <= 1'b0;
        end
        else if (long_hold_start && !long_hold_done) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD - 1;
            alloc_ch.ready <= 1'b0;
        end
        else if (sink_gap > 0) begin
            sink_gap--;
            alloc_ch.ready <= 1'b0;
        end
        else if (pending_q.size() > CALM_TAIL && $urandom_range(0, 99) < 20) begin
            sink_gap = $urandom_range(0, 4);
            alloc_ch.ready <= 1'b0;
        end
        else begin
            alloc_ch.ready <= 1'b1;
        end
    end

    // Monitor: checks result transfers, then predicts accepted instructions.
    always @(posedge clk) begin : watch_channels
        grant_t want;
        instr_t seen;
        req_taken <= instr_ch.valid && instr_ch.ready;
        if (alloc_ch.valid && alloc_ch.ready) begin
            if (grant_q.size() == 0) begin
                $display("%0t: result with nothing expected, actual dest %0d src %0d/%0d fault %0d",
                         $time, alloc_ch.dest_phys, alloc_ch.src_phys,
                         alloc_ch.src_phys_valid, alloc_ch.fault);
                mismatches++;
            end
            else begin
                want = grant_q.pop_front();
                if (alloc_ch.dest_phys !== want.dest_phys)
                    report_mismatch("dest_phys", want.dest_phys, alloc_ch.dest_phys);
                if (alloc_ch.src_phys !== want.src_phys)
                    report_mismatch("src_phys", want.src_phys, alloc_ch.src_phys);
                if (alloc_ch.src_phys_valid !== want.src_valid)
                    report_mismatch("src_phys_valid", want.src_valid, alloc_ch.src_phys_valid);
                if (alloc_ch.fault !== want.fault)
                    report_mismatch("fault", want.fault, alloc_ch.fault);
            end
        end
        if (instr_ch.valid && instr_ch.ready) begin
            seen.action     = instr_ch.action;
            seen.dest_vreg  = instr_ch.dest_vreg;
            seen.src_vreg   = instr_ch.src_vreg;
            seen.src_is_imm = instr_ch.src_is_imm;
            grant_q.push_back(predict_grant(seen));
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (instr_ch.valid && instr_ch.ready) || (alloc_ch.valid && alloc_ch.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int                    base;
        int                    roll;
        logic [PRA_ACTION_W-1:0] act;

        rst_n               = 1'b0;
        instr_ch.valid      = 1'b0;
        instr_ch.action     = '0;
        instr_ch.dest_vreg  = '0;
        instr_ch.src_vreg   = '0;
        instr_ch.src_is_imm = 1'b0;
        alloc_ch.ready      = 1'b0;
        mismatches          = 0;
        send_gap            = 0;
        sink_gap            = 0;
        long_hold_left      = 0;
        long_hold_start     = 1'b0;
        long_hold_done      = 1'b0;
        req_taken           = 1'b0;
        stalled_cycles      = 0;
        busy_regs           = '0;
        for (int i = 0; i < PRA_NUM_VIRT; i++) begin
            vmap_valid[i] = 1'b0;
            vmap_phys[i]  = '0;
        end

        // Directed opening: first-free picks and lookups of existing mappings.
        add_instr(ACT_ALLOC_DEST, 8'd0,   8'd255, 1'b1);
        add_instr(ACT_ALLOC_BOTH, 8'd255, 8'd0,   1'b0);
        // Source equal to destination shares the new register.
        add_instr(ACT_ALLOC_BOTH, 8'd10,  8'd10,  1'b0);
        // Immediate source gets no register.
        add_instr(ACT_ALLOC_BOTH, 8'd20,  8'd21,  1'b1);
        add_instr(ACT_ALLOC_DEST, 8'd255, 8'd255, 1'b0);
        // Release, then releases of a free and of an unmapped register.
        add_instr(ACT_RELEASE,    8'd20,  8'd0,   1'b0);
        add_instr(ACT_RELEASE,    8'd20,  8'd255, 1'b1);
        add_instr(ACT_RELEASE,    8'd99,  8'd0,   1'b0);
        // Stale mapping to a freed register.
        add_instr(ACT_ALLOC_DEST, 8'd20,  8'd0,   1'b0);
        add_instr(ACT_ALLOC_BOTH, 8'd30,  8'd20,  1'b0);
        // Unused action code with every bit set.
        add_instr(ACT_UNUSED,     8'd255, 8'd255, 1'b1);
        // Fill the register file, then run out.
        add_instr(ACT_ALLOC_BOTH, 8'd40,  8'd41,  1'b0);
        add_instr(ACT_ALLOC_BOTH, 8'd42,  8'd43,  1'b0);
        add_instr(ACT_ALLOC_DEST, 8'd50,  8'd0,   1'b0);
        add_instr(ACT_ALLOC_BOTH, 8'd0,   8'd51,  1'b0);
        // Destination fits but source does not: the destination is dropped.
        add_instr(ACT_RELEASE,    8'd40,  8'd0,   1'b0);
        add_instr(ACT_ALLOC_BOTH, 8'd60,  8'd61,  1'b0);
        add_instr(ACT_ALLOC_DEST, 8'd61,  8'd0,   1'b0);
        // Source with a stale mapping.
        add_instr(ACT_RELEASE,    8'd42,  8'd0,   1'b0);
        add_instr(ACT_ALLOC_BOTH, 8'd10,  8'd42,  1'b0);
        add_instr(ACT_RELEASE,    8'd255, 8'd0,   1'b0);
        add_instr(ACT_RELEASE,    8'd0,   8'd0,   1'b0);

        // Random traffic over a window of vregs that moves every 100 items.
        base = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                base = $urandom_range(0, PRA_NUM_VIRT - 16);
            roll = $urandom_range(0, 99);
            if (roll < 35)
                act = ACT_ALLOC_DEST;
            else if (roll < 65)
                act = ACT_ALLOC_BOTH;
            else if (roll < 95)
                act = ACT_RELEASE;
            else
                act = ACT_UNUSED;
            add_instr(act, pick_vreg(base), pick_vreg(base), $urandom_range(0, 9) < 3);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Hold the result side off for a long stretch while requests keep coming.
        wait (pending_q.size() < 1000);
        @(posedge clk);
        long_hold_start = 1'b1;

        // Drain: every item sent and every grant checked.
        do
            @(negedge clk);
        while (pending_q.size() != 0 || instr_ch.valid || grant_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && grant_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- physical_register_allocator.f -----
src/pra_pkg.sv
src/pra_if.sv
src/pra_ram.sv
src/pra_alloc.sv
src/physical_register_allocator.sv
src/pra_checker.sv
sim/testbench.sv
